/* hdl/glaa_pkg.sv */
// shared widths, sideband types and the cordic arctangent table
// used by every module of the look-at angle pipeline
package glaa_pkg;

    localparam int CW = 32;            // coordinate width, q15.16
    localparam int XW = 38;            // cordic x/y datapath width
    localparam int ZW = 27;            // angle accumulator, 1/65536 degree
    localparam int MW = 34;            // magnitude / distance width, unsigned
    localparam int MH = 17;            // split point of the gain multiply
    localparam int PW = 60;            // wide enough for the 30-bit gain constant
    localparam int GAIN_SHIFT = 30;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int PITCH_W = 15;
    localparam int YAW_W = 16;
    localparam int PITCH_LIM = 11520;
    localparam int YAW_LIM = 23040;

    localparam logic [29:0] INV_GAIN = 30'd652032874;
    localparam logic signed [ZW-1:0] ANG_180 = ZW'(180 * 65536);

    typedef struct packed {
        logic                 zero;
        logic signed [CW-1:0] dz;
    } t_yaw_side;

    typedef struct packed {
        logic                 zero;
        logic signed [ZW-1:0] yaw_z;
    } t_pitch_side;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic signed [ZW-1:0] v;
        unique case (i)
            0:  v = ZW'(2949120);
            1:  v = ZW'(1740967);
            2:  v = ZW'(919879);
            3:  v = ZW'(466945);
            4:  v = ZW'(234379);
            5:  v = ZW'(117304);
            6:  v = ZW'(58666);
            7:  v = ZW'(29335);
            8:  v = ZW'(14668);
            9:  v = ZW'(7334);
            10: v = ZW'(3667);
            11: v = ZW'(1833);
            12: v = ZW'(917);
            13: v = ZW'(458);
            14: v = ZW'(229);
            15: v = ZW'(115);
            16: v = ZW'(57);
            17: v = ZW'(29);
            18: v = ZW'(14);
            19: v = ZW'(7);
            20: v = ZW'(4);
            21: v = ZW'(2);
            22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/glaa_diff.sv */
// input stage: saturating target minus vehicle per axis
// depends on glaa_pkg
module glaa_diff import glaa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_tx,
    input  logic signed [CW-1:0] i_ty,
    input  logic signed [CW-1:0] i_tz,
    input  logic signed [CW-1:0] i_vx,
    input  logic signed [CW-1:0] i_vy,
    input  logic signed [CW-1:0] i_vz,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [CW-1:0] o_dx,
    output logic signed [CW-1:0] o_dy,
    output logic signed [CW-1:0] o_dz
);

    logic                 r_valid;
    logic signed [CW-1:0] r_dx, r_dy, r_dz;
    logic signed [CW-1:0] n_dx, n_dy, n_dz;

    function automatic logic signed [CW-1:0] sat_sub(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        logic signed [CW-1:0] r;
        d = {a[CW-1], a} - {b[CW-1], b};
        if (d[CW] != d[CW-1]) begin
            r = d[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            r = d[CW-1:0];
        end
        return r;
    endfunction

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_dx = sat_sub(i_tx, i_vx);
        n_dy = sat_sub(i_ty, i_vy);
        n_dz = sat_sub(i_tz, i_vz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_dz <= n_dz;
        end
    end

    assign o_valid = r_valid;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_dz    = r_dz;

endmodule

/* hdl/glaa_cstage.sv */
// one vectoring cordic iteration with its own pipeline register
// depends on glaa_pkg for widths and the arctangent table
module glaa_cstage import glaa_pkg::*; #(
    parameter int SHIFT = 0,
    parameter int SW    = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic [SW-1:0]        o_side
);

    localparam logic signed [ZW-1:0] ANG = atan_val(SHIFT);

    logic                 r_valid;
    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic [SW-1:0]        r_side;
    logic signed [XW-1:0] xs, ys;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        xs = i_x >>> SHIFT;
        ys = i_y >>> SHIFT;
        if (!i_y[XW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ANG;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

/* hdl/glaa_scale.sv */
// cordic gain correction of the horizontal magnitude, two stages:
// split partial products, then sum and round; depends on glaa_pkg
module glaa_scale import glaa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [XW-1:0] i_mag,
    input  logic signed [ZW-1:0] i_z,
    input  t_yaw_side            i_side,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [MW-1:0]        o_dist,
    output logic signed [ZW-1:0] o_yaw_z,
    output logic signed [CW-1:0] o_dz
);

    logic                 r_v1, r_v2, rdy1, rdy2;
    logic [PW-1:0]        r_plo, r_phi, n_plo, n_phi;
    logic signed [ZW-1:0] r_z1, r_z2;
    t_yaw_side            r_side1;
    logic [MW-1:0]        r_dist, n_dist, mag_u;
    logic signed [CW-1:0] r_dz2;
    logic [PW+MH:0]       sum;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        mag_u = i_mag[XW-1] ? '0 : i_mag[MW-1:0];
        n_plo = PW'(mag_u[MH-1:0]) * PW'(INV_GAIN);
        n_phi = PW'(mag_u[MW-1:MH]) * PW'(INV_GAIN);
        sum   = ({{(MH+1){1'b0}}, r_phi} << MH) + {{(MH+1){1'b0}}, r_plo}
              + ((PW+MH+1)'(1) << (GAIN_SHIFT - 1));
        n_dist = r_side1.zero ? '0 : sum[GAIN_SHIFT +: MW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_plo   <= n_plo;
            r_phi   <= n_phi;
            r_z1    <= i_z;
            r_side1 <= i_side;
        end
        if (rdy2 && r_v1) begin
            r_dist <= n_dist;
            r_z2   <= r_side1.zero ? '0 : r_z1;
            r_dz2  <= r_side1.dz;
        end
    end

    assign o_valid = r_v2;
    assign o_dist  = r_dist;
    assign o_yaw_z = r_z2;
    assign o_dz    = r_dz2;

endmodule

/* hdl/glaa_out.sv */
// output register: rounds both angles to 1/128 degree and clamps
// depends on glaa_pkg
module glaa_out import glaa_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [ZW-1:0]      i_pitch_z,
    input  t_pitch_side               i_side,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [PITCH_W-1:0] o_pitch,
    output logic signed [YAW_W-1:0]   o_yaw
);

    localparam int RW = ZW - 8;

    logic                      r_valid;
    logic signed [PITCH_W-1:0] r_pitch, n_pitch;
    logic signed [YAW_W-1:0]   r_yaw, n_yaw;
    logic signed [ZW:0]        tp, ty;
    logic signed [RW-1:0]      rp, ry;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        tp = (i_side.zero ? (ZW+1)'(0) : {i_pitch_z[ZW-1], i_pitch_z}) + (ZW+1)'(256);
        ty = -{i_side.yaw_z[ZW-1], i_side.yaw_z} + (ZW+1)'(256);
        rp = RW'(tp >>> 9);
        ry = RW'(ty >>> 9);
        if (rp > RW'(PITCH_LIM))       n_pitch = PITCH_W'(PITCH_LIM);
        else if (rp < -RW'(PITCH_LIM)) n_pitch = -PITCH_W'(PITCH_LIM);
        else                           n_pitch = rp[PITCH_W-1:0];
        if (ry > RW'(YAW_LIM))         n_yaw = YAW_W'(YAW_LIM);
        else if (ry < -RW'(YAW_LIM))   n_yaw = -YAW_W'(YAW_LIM);
        else                           n_yaw = ry[YAW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pitch <= n_pitch;
            r_yaw   <= n_yaw;
        end
    end

    assign o_valid = r_valid;
    assign o_pitch = r_pitch;
    assign o_yaw   = r_yaw;

endmodule

/* hdl/gimbal_look_at_angles_top.sv */
// Look-at angle pipeline: one pose pair in, one pitch/yaw pair out, one beat per cycle
// sustained while the output is not stalled. Stages: a difference stage, CORDIC_STEPS
// yaw cordic stages, two gain-correction stages, CORDIC_STEPS pitch cordic stages and
// the output register. Every stage has its own valid bit and a stall backs up only as
// far as the first empty stage. Angles are in 1/128 degree; a zero vector gives 0.
module gimbal_look_at_angles_top import glaa_pkg::*; #(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [CW-1:0]      i_target_x,
    input  logic signed [CW-1:0]      i_target_y,
    input  logic signed [CW-1:0]      i_target_z,
    input  logic signed [CW-1:0]      i_vehicle_x,
    input  logic signed [CW-1:0]      i_vehicle_y,
    input  logic signed [CW-1:0]      i_vehicle_z,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [PITCH_W-1:0] o_pitch_angle,
    output logic signed [YAW_W-1:0]   o_yaw_angle
);

    localparam int N = CORDIC_STEPS;

    logic                 d_valid, d_ready;
    logic signed [CW-1:0] d_dx, d_dy, d_dz;

    logic                 yv [0:N];
    logic                 yr [0:N];
    logic signed [XW-1:0] yx [0:N];
    logic signed [XW-1:0] yy [0:N];
    logic signed [ZW-1:0] yz [0:N];
    t_yaw_side            ys [0:N];

    logic                 s_valid, s_ready;
    logic [MW-1:0]        s_dist;
    logic signed [ZW-1:0] s_yaw_z;
    logic signed [CW-1:0] s_dz;

    logic                 pv [0:N];
    logic                 pr [0:N];
    logic signed [XW-1:0] px [0:N];
    logic signed [XW-1:0] py [0:N];
    logic signed [ZW-1:0] pz [0:N];
    t_pitch_side          ps [0:N];

    glaa_diff u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_tx    (i_target_x),
        .i_ty    (i_target_y),
        .i_tz    (i_target_z),
        .i_vx    (i_vehicle_x),
        .i_vy    (i_vehicle_y),
        .i_vz    (i_vehicle_z),
        .o_valid (d_valid),
        .i_ready (d_ready),
        .o_dx    (d_dx),
        .o_dy    (d_dy),
        .o_dz    (d_dz)
    );

    // negative x: turn the vector by 180 degrees first
    always_comb begin
        yv[0]      = d_valid;
        d_ready    = yr[0];
        ys[0].zero = (d_dx == '0) && (d_dy == '0);
        ys[0].dz   = d_dz;
        if (d_dx[CW-1]) begin
            yx[0] = -XW'(d_dx);
            yy[0] = -XW'(d_dy);
            yz[0] = d_dy[CW-1] ? -ANG_180 : ANG_180;
        end else begin
            yx[0] = XW'(d_dx);
            yy[0] = XW'(d_dy);
            yz[0] = '0;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_yaw
        glaa_cstage #(.SHIFT(k), .SW($bits(t_yaw_side))) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (yv[k]),
            .o_ready (yr[k]),
            .i_x     (yx[k]),
            .i_y     (yy[k]),
            .i_z     (yz[k]),
            .i_side  (ys[k]),
            .o_valid (yv[k+1]),
            .i_ready (yr[k+1]),
            .o_x     (yx[k+1]),
            .o_y     (yy[k+1]),
            .o_z     (yz[k+1]),
            .o_side  (ys[k+1])
        );
    end

    glaa_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (yv[N]),
        .o_ready (yr[N]),
        .i_mag   (yx[N]),
        .i_z     (yz[N]),
        .i_side  (ys[N]),
        .o_valid (s_valid),
        .i_ready (s_ready),
        .o_dist  (s_dist),
        .o_yaw_z (s_yaw_z),
        .o_dz    (s_dz)
    );

    always_comb begin
        pv[0]       = s_valid;
        s_ready     = pr[0];
        px[0]       = XW'(s_dist);
        py[0]       = XW'(s_dz);
        pz[0]       = '0;
        ps[0].zero  = (s_dist == '0) && (s_dz == '0);
        ps[0].yaw_z = s_yaw_z;
    end

    for (genvar k = 0; k < N; k++) begin : g_pitch
        glaa_cstage #(.SHIFT(k), .SW($bits(t_pitch_side))) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (pv[k]),
            .o_ready (pr[k]),
            .i_x     (px[k]),
            .i_y     (py[k]),
            .i_z     (pz[k]),
            .i_side  (ps[k]),
            .o_valid (pv[k+1]),
            .i_ready (pr[k+1]),
            .o_x     (px[k+1]),
            .o_y     (py[k+1]),
            .o_z     (pz[k+1]),
            .o_side  (ps[k+1])
        );
    end

    glaa_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (pv[N]),
        .o_ready   (pr[N]),
        .i_pitch_z (pz[N]),
        .i_side    (ps[N]),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_pitch   (o_pitch_angle),
        .o_yaw     (o_yaw_angle)
    );

endmodule

/* hdl/glaa_checker.sv */
// port-level checks on the look-at angle pipeline, bound to the top level
// depends on glaa_pkg for output widths and limits
module glaa_checker import glaa_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic signed [PITCH_W-1:0] o_pitch_angle,
    input logic signed [YAW_W-1:0]   o_yaw_angle
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pitch_angle)
                                        && $stable(o_yaw_angle))
        else $error("stalled result beat changed");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pitch_angle <= PITCH_W'(PITCH_LIM)
                        && o_pitch_angle >= -PITCH_W'(PITCH_LIM))
        else $error("pitch out of range");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_yaw_angle <= YAW_W'(YAW_LIM) && o_yaw_angle >= -YAW_W'(YAW_LIM))
        else $error("yaw out of range");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with an empty output");

endmodule

bind gimbal_look_at_angles_top glaa_checker u_glaa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pitch_angle (o_pitch_angle),
    .o_yaw_angle   (o_yaw_angle)
);

/* verif/tb.sv */
// testbench for the look-at angle pipeline: random and corner pose pairs, a local
// pitch/yaw model, and a scoreboard that checks every output beat in order
// depends on glaa_pkg and gimbal_look_at_angles_top
module tb;
    import glaa_pkg::*;

    localparam int STEPS   = DEF_CORDIC_STEPS;
    localparam int LATENCY = 2 * STEPS + 4;
    localparam longint MAX_CYCLES = 400000;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [YAW_W-1:0]   yaw;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [CW-1:0] i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic signed [CW-1:0] i_vehicle_x = '0, i_vehicle_y = '0, i_vehicle_z = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [PITCH_W-1:0] o_pitch_angle;
    logic signed [YAW_W-1:0]   o_yaw_angle;

    t_angles angles_due[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    longint cycle = 0;

    gimbal_look_at_angles_top #(.CORDIC_STEPS(STEPS)) u_top (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint sat_diff(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        return d;
    endfunction

    function automatic longint atan_units(int i);
        longint tab[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
        return (i < 23) ? tab[i] : 0;
    endfunction

    // vectoring rotation; returns angle in 1/65536 degree, mag through an output argument
    function automatic longint rotate_to_axis(longint x, longint y, longint z,
                                              output longint mag);
        longint xs, ys;
        for (int i = 0; i < STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + atan_units(i);
            end else begin
                x = x - ys; y = y + xs; z = z - atan_units(i);
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic longint to_out_units(longint z, longint lim);
        longint r;
        r = (z + 256) >>> 9;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles look_at(logic signed [CW-1:0] tx, ty, tz, vx, vy, vz);
        longint dx, dy, dz, x, y, z0, yaw_z, pitch_z, mag, hdist;
        logic [63:0] prod;
        t_angles a;
        dx = sat_diff(tx, vx);
        dy = sat_diff(ty, vy);
        dz = sat_diff(tz, vz);
        yaw_z = 0; pitch_z = 0; hdist = 0; mag = 0;
        if (dx != 0 || dy != 0) begin
            x = dx; y = dy; z0 = 0;
            if (dx < 0) begin
                x = -dx; y = -dy;
                z0 = (dy >= 0) ? 180 * 65536 : -180 * 65536;
            end
            yaw_z = rotate_to_axis(x, y, z0, mag);
            if (mag < 0) mag = 0;
            prod = 64'(mag) * 64'd652032874 + (64'd1 << 29);
            hdist = longint'(prod >> 30);
        end
        if (hdist != 0 || dz != 0) pitch_z = rotate_to_axis(hdist, dz, 0, mag);
        a.pitch = PITCH_W'(to_out_units(pitch_z, PITCH_LIM));
        a.yaw = YAW_W'(to_out_units(-yaw_z, YAW_LIM));
        return a;
    endfunction

    task automatic send_pose(logic signed [CW-1:0] tx, ty, tz, vx, vy, vz);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_target_x <= tx; i_target_y <= ty; i_target_z <= tz;
        i_vehicle_x <= vx; i_vehicle_y <= vy; i_vehicle_z <= vz;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        angles_due.push_back(look_at(tx, ty, tz, vx, vy, vz));
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // output beat checker
    always @(posedge i_clk) begin
        t_angles want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (angles_due.size() == 0) begin
                $error("unexpected beat pitch=%0d yaw=%0d", o_pitch_angle, o_yaw_angle);
                errors++;
            end else begin
                want = angles_due.pop_front();
                if (o_pitch_angle !== want.pitch) begin
                    $error("pitch_angle expected %0d got %0d", want.pitch, o_pitch_angle);
                    errors++;
                end
                if (o_yaw_angle !== want.yaw) begin
                    $error("yaw_angle expected %0d got %0d", want.yaw, o_yaw_angle);
                    errors++;
                end
            end
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return CW'($signed($urandom_range(2000)) - 1000);
            2: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'($urandom)} >>> $urandom_range(31);
            3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return CW'($signed($urandom_range(65536 * 200)) - 65536 * 100);
        endcase
    endfunction

    task automatic send_random(int n);
        logic [CW-1:0] vx, vy, vz;
        for (int i = 0; i < n; i++) begin
            vx = rand_coord(); vy = rand_coord(); vz = rand_coord();
            // sometimes share an axis so zero differences occur
            send_pose($urandom_range(7) == 0 ? vx : rand_coord(),
                      $urandom_range(7) == 0 ? vy : rand_coord(),
                      $urandom_range(7) == 0 ? vz : rand_coord(), vx, vy, vz);
        end
    endtask

    task automatic wait_drained();
        if (i_in_valid) i_in_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_corners();
        localparam logic signed [CW-1:0] MX = 32'sh7fffffff, MN = 32'sh80000000;
        localparam logic signed [CW-1:0] ONE = 32'sh00010000;
        send_pose(0, 0, 0, 0, 0, 0);                // zero vector
        send_pose(5, 5, 7, 5, 5, 0);                // straight up
        send_pose(5, 5, -ONE, 5, 5, 0);             // straight down
        send_pose(ONE, 0, 0, 0, 0, 0);              // ahead
        send_pose(-ONE, 0, 0, 0, 0, 0);             // straight behind
        send_pose(-ONE, -1, 0, 0, 0, 0);            // behind, slightly negative y
        send_pose(0, ONE, 0, 0, 0, 0);
        send_pose(0, -ONE, 0, 0, 0, 0);
        send_pose(ONE, ONE, ONE, 0, 0, 0);
        send_pose(MX, MX, MX, MN, MN, MN);          // positive saturation
        send_pose(MN, MN, MN, MX, MX, MX);          // negative saturation
        send_pose(MX, MN, MX, MN, MX, MN);
        send_pose(MN, 0, MX, MX, 0, MN);
        send_pose(1, 0, 0, 0, 0, 0);
        send_pose(0, 0, 1, 0, 0, 0);
        send_pose(0, 0, -1, 0, 0, 0);
        send_pose(-1, -1, -1, 0, 0, 0);
        send_pose(32'hffffffff, 32'h55555555, 32'haaaaaaaa, 0, 32'h12345678, 32'hedcba987);
        wait_drained();
    endtask

    task automatic test_idle_phase(int s_pct, int r_pct, int n);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        send_random(n);
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_off <= 3 * LATENCY;
        send_random(4 * LATENCY);
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_idle_phase(0, 0, 300);
        test_idle_phase(64, 0, 250);
        test_idle_phase(0, 64, 250);
        test_idle_phase(37, 37, 250);
        test_backpressure();
        wait_drained();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
